FILE: src/tpba_pkg.sv
`timescale 1ns / 1ps

package tpba_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned BytesW = 32;
  localparam int unsigned GenW   = 64;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [CountW-1:0] LimitReset  = 16'd64;
  localparam logic [BytesW-1:0] BudgetReset = 32'd16777216;
  localparam logic [GenW-1:0]   GenReset    = 64'd1;

  typedef enum logic [1:0] {
    CMD_RESERVE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_CLOSE   = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CLOSED    = 3'd1,
    ST_POOL_FULL = 3'd2,
    ST_NO_BUDGET = 3'd3,
    ST_UNDERFLOW = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_P0_LIMIT  = 2'd0,
    REG_P0_BUDGET = 2'd1,
    REG_P1_LIMIT  = 2'd2,
    REG_P1_BUDGET = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CountW-1:0] limit0;
    logic [BytesW-1:0] budget0;
    logic [CountW-1:0] limit1;
    logic [BytesW-1:0] budget1;
  } cfg_t;

  typedef struct packed {
    status_e           status;
    logic              closing;
    logic [GenW-1:0]   gen;
    logic [CountW-1:0] count;
    logic [BytesW-1:0] bytes;
    logic [CountW-1:0] count_peak;
    logic [BytesW-1:0] bytes_peak;
  } result_t;

endpackage

FILE: src/tpba_cfg.sv
`timescale 1ns / 1ps

module tpba_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpba_pkg::AddrW-1:0]    paddr,
  input  logic [tpba_pkg::DataW-1:0]    pwdata,
  output logic [tpba_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output tpba_pkg::cfg_t                cfg_o
);

  tpba_pkg::cfg_t     cfg_q;
  tpba_pkg::reg_idx_e idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = tpba_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit0  <= tpba_pkg::LimitReset;
      cfg_q.budget0 <= tpba_pkg::BudgetReset;
      cfg_q.limit1  <= tpba_pkg::LimitReset;
      cfg_q.budget1 <= tpba_pkg::BudgetReset;
    end else if (wr_en) begin
      case (idx)
        tpba_pkg::REG_P0_LIMIT:  cfg_q.limit0  <= pwdata[tpba_pkg::CountW-1:0];
        tpba_pkg::REG_P0_BUDGET: cfg_q.budget0 <= pwdata[tpba_pkg::BytesW-1:0];
        tpba_pkg::REG_P1_LIMIT:  cfg_q.limit1  <= pwdata[tpba_pkg::CountW-1:0];
        tpba_pkg::REG_P1_BUDGET: cfg_q.budget1 <= pwdata[tpba_pkg::BytesW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tpba_pkg::REG_P0_LIMIT:  prdata = {16'd0, cfg_q.limit0};
      tpba_pkg::REG_P0_BUDGET: prdata = cfg_q.budget0;
      tpba_pkg::REG_P1_LIMIT:  prdata = {16'd0, cfg_q.limit1};
      tpba_pkg::REG_P1_BUDGET: prdata = cfg_q.budget1;
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/tpba_core.sv
`timescale 1ns / 1ps

module tpba_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  input  tpba_pkg::cmd_e                    cmd_i,
  input  logic                              pool_i,
  input  logic [tpba_pkg::BytesW-1:0]       bytes_i,
  input  logic [tpba_pkg::GenW-1:0]         gen_i,
  input  tpba_pkg::cfg_t                    cfg_i,
  output tpba_pkg::result_t                 res_o
);

  logic                          closed_q, closed_d;
  logic [tpba_pkg::GenW-1:0]     gen_q, gen_d;
  logic [tpba_pkg::CountW-1:0]   cnt_q   [2];
  logic [tpba_pkg::BytesW-1:0]   byt_q   [2];
  logic [tpba_pkg::CountW-1:0]   cpk_q   [2];
  logic [tpba_pkg::BytesW-1:0]   bpk_q   [2];

  logic [tpba_pkg::CountW-1:0]   cnt_cur, cnt_d, cpk_cur, cpk_d, limit;
  logic [tpba_pkg::BytesW-1:0]   byt_cur, byt_d, bpk_cur, bpk_d, budget;
  logic [tpba_pkg::GenW-1:0]     gen_inc;
  tpba_pkg::status_e             status;

  assign cnt_cur = cnt_q[pool_i];
  assign byt_cur = byt_q[pool_i];
  assign cpk_cur = cpk_q[pool_i];
  assign bpk_cur = bpk_q[pool_i];
  assign limit   = pool_i ? cfg_i.limit1  : cfg_i.limit0;
  assign budget  = pool_i ? cfg_i.budget1 : cfg_i.budget0;
  assign gen_inc = gen_q + 64'd1;

  always_comb begin
    status   = tpba_pkg::ST_OK;
    closed_d = closed_q;
    gen_d    = gen_q;
    cnt_d    = cnt_cur;
    byt_d    = byt_cur;
    cpk_d    = cpk_cur;
    bpk_d    = bpk_cur;
    case (cmd_i)
      tpba_pkg::CMD_RESERVE: begin
        if (closed_q || (gen_q != gen_i)) begin
          status = tpba_pkg::ST_CLOSED;
        end else if (cnt_cur >= limit) begin
          status = tpba_pkg::ST_POOL_FULL;
        end else if ((bytes_i == '0) || (bytes_i > budget) ||
                     (byt_cur > (budget - bytes_i))) begin
          status = tpba_pkg::ST_NO_BUDGET;
        end else begin
          cnt_d = cnt_cur + 16'd1;
          byt_d = byt_cur + bytes_i;
          if (cnt_d > cpk_cur) begin
            cpk_d = cnt_d;
          end
          if (byt_d > bpk_cur) begin
            bpk_d = byt_d;
          end
        end
      end
      tpba_pkg::CMD_RELEASE: begin
        if ((cnt_cur == '0) || (byt_cur < bytes_i)) begin
          status = tpba_pkg::ST_UNDERFLOW;
        end else begin
          cnt_d = cnt_cur - 16'd1;
          byt_d = byt_cur - bytes_i;
        end
      end
      tpba_pkg::CMD_CLOSE: begin
        if (!closed_q) begin
          closed_d = 1'b1;
          // The generation never takes the value zero, even on wrap.
          gen_d    = (gen_inc == '0) ? 64'd1 : gen_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_q <= 1'b0;
      gen_q    <= tpba_pkg::GenReset;
      cnt_q    <= '{default: '0};
      byt_q    <= '{default: '0};
      cpk_q    <= '{default: '0};
      bpk_q    <= '{default: '0};
    end else if (fire_i) begin
      closed_q        <= closed_d;
      gen_q           <= gen_d;
      cnt_q[pool_i]   <= cnt_d;
      byt_q[pool_i]   <= byt_d;
      cpk_q[pool_i]   <= cpk_d;
      bpk_q[pool_i]   <= bpk_d;
    end
  end

  always_comb begin
    res_o.status     = status;
    res_o.closing    = closed_d;
    res_o.gen        = closed_d ? '0 : gen_d;
    res_o.count      = cnt_d;
    res_o.bytes      = byt_d;
    res_o.count_peak = cpk_d;
    res_o.bytes_peak = bpk_d;
  end

`ifndef ASSERT_OFF
  a_peak_cnt0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cpk_q[0] >= cnt_q[0]) else $error("pool 0 request peak below count");
  a_peak_byt1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bpk_q[1] >= byt_q[1]) else $error("pool 1 byte peak below count");
  a_gen_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_q != '0) else $error("generation became zero");
  a_close_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(closed_q)) else $error("closed flag cleared");
`endif

endmodule

FILE: src/two_pool_request_byte_admission.sv
`timescale 1ns / 1ps

// Each item is held in the input register while the decision and state update
// are made, and its result is then written to the result register, from which
// it is taken; decision and state update sit between the two registers.
// Throughput: one item per cycle, limited only by back-pressure on the result.
// Reset clears all counters, peaks and the closed flag, sets the generation to
// one and the configuration registers to their default limits and budgets.
module two_pool_request_byte_admission (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tpba_pkg::AddrW-1:0]      paddr,
  input  logic [tpba_pkg::DataW-1:0]      pwdata,
  output logic [tpba_pkg::DataW-1:0]      prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      command_i,
  input  logic                            pool_i,
  input  logic [31:0]                     byte_count_i,
  input  logic [63:0]                     client_generation_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [2:0]                      status_o,
  output logic                            is_closing_o,
  output logic [63:0]                     current_generation_o,
  output logic [15:0]                     active_count_o,
  output logic [31:0]                     active_total_bytes_o,
  output logic [15:0]                     count_peak_o,
  output logic [31:0]                     bytes_peak_o
);

  tpba_pkg::cfg_t    cfg;
  tpba_pkg::result_t res, res_q;

  logic              in_valid_q, out_valid_q;
  tpba_pkg::cmd_e    cmd_q;
  logic              pool_q;
  logic [31:0]       bytes_q;
  logic [63:0]       gen_q;
  logic              advance, fire, accept;

  tpba_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The held item moves on whenever the result register is free or being taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance || !in_valid_q) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= tpba_pkg::cmd_e'(command_i);
      pool_q  <= pool_i;
      bytes_q <= byte_count_i;
      gen_q   <= client_generation_i;
    end
  end

  tpba_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .cmd_i   (cmd_q),
    .pool_i  (pool_q),
    .bytes_i (bytes_q),
    .gen_i   (gen_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = res_q.status;
  assign is_closing_o         = res_q.closing;
  assign current_generation_o = res_q.gen;
  assign active_count_o       = res_q.count;
  assign active_total_bytes_o = res_q.bytes;
  assign count_peak_o         = res_q.count_peak;
  assign bytes_peak_o         = res_q.bytes_peak;

endmodule
